// ===== hw/rtl/wbps_pkg.sv =====
package wbps_pkg;

    // Field widths of the stream payload
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 7;
    localparam int LEN_W   = 8;
    localparam int ADDR_W  = 32;
    localparam int CFG_W   = 32;
    localparam int IN_DATA_W = 24;

    // Match bits folded per group in the first reduction stage
    localparam int GROUP_SIZE = 32;

    // Request kinds carried in tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_SCAN = 1'b1;

    // Configuration register indexes
    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_REGION_BASE    = 1'b1;

    // Broadcast control for the window cells
    typedef struct packed {
        logic scan;
        logic clear;
        logic up;
        logic down;
        logic load;
    } t_cell_ctl;

    // First pipeline stage, handed to the decision stage
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ADDR_W-1:0] seen;
    } t_s1_info;

endpackage

// ===== hw/rtl/wbps_cell.sv =====
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 128,
    parameter int IDX         = 0,
    localparam int LW         = $clog2(MAX_PATTERN + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [LW-1:0]     i_align,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [IDX_W-1:0]  i_load_index,
    input  logic [BYTE_W-1:0] i_pattern_byte,
    input  logic              i_is_wildcard,
    input  logic [BYTE_W-1:0] i_from_above,
    input  logic [BYTE_W-1:0] i_from_below,
    output logic [BYTE_W-1:0] o_win,
    output logic              o_ok
);

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] n_win;
    logic [BYTE_W-1:0] n_shift;
    logic [BYTE_W-1:0] r_pat;
    logic              r_wild;
    logic              r_ok;
    logic              n_ok;
    logic              w_sel;

    // Newest byte enters at the cell aligned with the last pattern entry
    assign n_shift = (i_align == LW'(IDX + 1)) ? i_data_byte : i_from_above;

    // Cells past the pattern length always agree
    assign n_ok = (LW'(IDX) >= i_align) || r_wild || (n_shift == r_pat);

    assign w_sel = (IDX < (1 << IDX_W)) && (i_load_index == IDX_W'(IDX));

    // Pick next window byte: shift (or clear on the last byte) on a scan, walk up or down on realign
    always_comb begin
        n_win = r_win;
        priority if (i_ctl.scan) begin
            n_win = i_ctl.clear ? '0 : n_shift;
        end else if (i_ctl.up) begin
            n_win = i_from_below;
        end else if (i_ctl.down) begin
            n_win = i_from_above;
        end else begin
            n_win = r_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            r_win <= n_win;
        end
    end

    // Hold pattern entry and the match bit of the latest scan
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && w_sel) begin
            r_pat  <= i_pattern_byte;
            r_wild <= i_is_wildcard;
        end
        if (i_ctl.scan) begin
            r_ok <= n_ok;
        end
    end

    assign o_win = r_win;
    assign o_ok  = r_ok;

endmodule

// ===== hw/rtl/wbps_decide.sv =====
module wbps_decide
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 128,
    localparam int LW         = $clog2(MAX_PATTERN + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_s1_info               i_s1,
    input  logic [MAX_PATTERN-1:0] i_ok,
    input  logic [LW-1:0]          i_len_eff,
    input  logic [ADDR_W-1:0]      i_base,
    output logic                   o_s1_pop,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [ADDR_W-1:0]      o_m_tdata,
    output logic                   o_m_tuser
);

    localparam int NG = (MAX_PATTERN + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [NG-1:0]     w_grp;
    logic [NG-1:0]     r_s2_grp;
    logic              r_s2_valid;
    logic              r_s2_last;
    logic              r_s2_ge;
    logic [ADDR_W-1:0] r_s2_off;
    logic              r_out_valid;
    logic              r_out_found;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_match_reported;
    logic              w_out_free;
    logic              w_s2_move;
    logic              w_s2_free;
    logic              w_hit;
    logic              w_emit;

    // Fold the cell match bits in groups
    for (genvar g = 0; g < NG; g++) begin : g_grp
        localparam int LO = g * GROUP_SIZE;
        localparam int HI = (LO + GROUP_SIZE - 1 < MAX_PATTERN) ?
                            LO + GROUP_SIZE - 1 : MAX_PATTERN - 1;
        assign w_grp[g] = &i_ok[HI:LO];
    end

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_s2_move  = r_s2_valid && w_out_free;
    assign w_s2_free  = !r_s2_valid || w_s2_move;
    assign o_s1_pop   = i_s1.valid && w_s2_free;

    assign w_hit  = r_s2_ge && (&r_s2_grp) && !r_match_reported;
    assign w_emit = w_s2_move && (w_hit || (r_s2_last && !r_match_reported));

    // Stage two: group bits, length check and start offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_s1_pop) begin
            r_s2_valid <= 1'b1;
        end else if (w_s2_move) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_pop) begin
            r_s2_grp  <= w_grp;
            r_s2_last <= i_s1.last;
            r_s2_ge   <= (i_s1.seen >= ADDR_W'(i_len_eff)) && (i_len_eff != '0);
            r_s2_off  <= i_s1.seen - ADDR_W'(i_len_eff);
        end
    end

    // Decide once per byte in order, remember a reported match per region
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_reported <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (w_s2_move) begin
                if (r_s2_last) begin
                    r_match_reported <= 1'b0;
                end else if (w_hit) begin
                    r_match_reported <= 1'b1;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_found <= w_hit;
            r_out_addr  <= w_hit ? (i_base + r_s2_off) : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_addr;
    assign o_m_tuser  = r_out_found;

`ifndef NO_ASSERTIONS
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_addr == '0))
        else $error("not-found result carries a nonzero address");

    a_found_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_hit && !r_s2_last) |=> r_match_reported)
        else $error("match reported without marking the region");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result produced while output register is occupied");
`endif

endmodule

// ===== hw/rtl/wildcard_byte_pattern_scan.sv =====
// Wildcard byte pattern scan.
// Input stream: tuser selects the request kind (load a pattern entry or scan one
// region byte), tlast marks the final byte of a region. Configuration writes set
// pattern_length and region_base and must only occur while the block is idle.
// Output stream: exactly one result per region; tuser is found, tdata the match
// address (region_base plus start offset) or zero when the region had no match.
// Throughput: one request per cycle, loads and scans alike, while the row is
// aligned and the output path has room. A scan's result passes the match-bit
// stage in the cells, the group-reduction stage and the output register.
// The window is a row of byte cells aligned with the pattern entries; after a
// pattern_length write the row walks one cell per cycle to the new alignment,
// and input is held off until the row has reached it.
// Reset: length and base return to zero, the window clears, the pattern entries
// stay undefined until loaded. When the receiver stalls, the output register
// holds its result and the two internal stages keep filling, so input is held
// off only once both are occupied.
module wildcard_byte_pattern_scan
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [6:0] entry_index, [14:7] pattern_byte, [15] is_wildcard, [23:16] data_byte
    input  logic [IN_DATA_W-1:0] i_s_tdata,
    // [0] func
    input  logic                 i_s_tuser,
    input  logic                 i_s_tlast,
    // Result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [31:0] match_address
    output logic [ADDR_W-1:0]    o_m_tdata,
    // [0] found
    output logic                 o_m_tuser,
    // Configuration
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int CW = (LW > LEN_W) ? LW : LEN_W;

    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_base;
    logic [LW-1:0]     r_align;
    logic [LW-1:0]     w_len_eff;
    logic              w_aligned;
    logic              w_accept;
    t_cell_ctl         w_ctl;
    logic [ADDR_W-1:0] r_seen;
    logic [ADDR_W-1:0] n_seen;
    logic              r_s1_valid;
    logic              r_s1_last;
    logic [ADDR_W-1:0] r_s1_seen;
    logic              w_s1_pop;
    logic              w_s1_free;
    t_s1_info          w_s1;
    logic [BYTE_W-1:0] w_data_byte;
    logic [BYTE_W-1:0] w_win [MAX_PATTERN];
    logic [BYTE_W-1:0] r_hist [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_ok;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_base <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PATTERN_LENGTH: r_len  <= i_cfg_data[LEN_W-1:0];
                REG_REGION_BASE:    r_base <= i_cfg_data;
                default:            r_base <= r_base;
            endcase
        end
    end

    // Clamp the length to the number of cells
    assign w_len_eff = (CW'(r_len) > CW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(r_len);
    assign w_aligned = (r_align == w_len_eff);

    // Walk the row one cell per cycle toward the configured length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= '0;
        end else if (w_ctl.up) begin
            r_align <= r_align + LW'(1);
        end else if (w_ctl.down) begin
            r_align <= r_align - LW'(1);
        end
    end

    assign w_s1_free  = !r_s1_valid || w_s1_pop;
    assign o_s_tready = w_s1_free && w_aligned;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_ctl.scan  = w_accept && (i_s_tuser == FUNC_SCAN);
    assign w_ctl.load  = w_accept && (i_s_tuser == FUNC_LOAD);
    assign w_ctl.clear = w_ctl.scan && i_s_tlast;
    assign w_ctl.up    = (r_align < w_len_eff);
    assign w_ctl.down  = (r_align > w_len_eff);

    assign w_data_byte = i_s_tdata[23:16];

    // Saturating byte count of the region
    assign n_seen = (r_seen == '1) ? r_seen : r_seen + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_ctl.scan) begin
            r_seen <= w_ctl.clear ? '0 : n_seen;
        end
    end

    // Stage one: scan token beside the cell match bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_ctl.scan) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_pop) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.scan) begin
            r_s1_last <= i_s_tlast;
            r_s1_seen <= n_seen;
        end
    end

    assign w_s1.valid = r_s1_valid;
    assign w_s1.last  = r_s1_last;
    assign w_s1.seen  = r_s1_seen;

    // History cells below the pattern row keep older bytes for realignment
    for (genvar m = 0; m < MAX_PATTERN; m++) begin : g_hist
        logic [BYTE_W-1:0] w_above;
        logic [BYTE_W-1:0] w_scan_in;
        logic [BYTE_W-1:0] w_below;

        if (m == MAX_PATTERN - 1) begin : g_top
            assign w_above   = w_win[0];
            assign w_scan_in = (r_align == '0) ? w_data_byte : w_win[0];
        end else begin : g_mid
            assign w_above   = r_hist[m+1];
            assign w_scan_in = r_hist[m+1];
        end

        if (m == 0) begin : g_bot
            assign w_below = '0;
        end else begin : g_rest
            assign w_below = r_hist[m-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hist[m] <= '0;
            end else if (w_ctl.scan) begin
                r_hist[m] <= w_ctl.clear ? '0 : w_scan_in;
            end else if (w_ctl.up) begin
                r_hist[m] <= w_below;
            end else if (w_ctl.down) begin
                r_hist[m] <= w_above;
            end
        end
    end

    // Pattern row: one cell per pattern entry
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_row
        logic [BYTE_W-1:0] w_above;
        logic [BYTE_W-1:0] w_below;

        if (j == MAX_PATTERN - 1) begin : g_top
            assign w_above = '0;
        end else begin : g_mid
            assign w_above = w_win[j+1];
        end

        if (j == 0) begin : g_bot
            assign w_below = r_hist[MAX_PATTERN-1];
        end else begin : g_rest
            assign w_below = w_win[j-1];
        end

        wbps_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .IDX         (j)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_align        (r_align),
            .i_data_byte    (w_data_byte),
            .i_load_index   (i_s_tdata[6:0]),
            .i_pattern_byte (i_s_tdata[14:7]),
            .i_is_wildcard  (i_s_tdata[15]),
            .i_from_above   (w_above),
            .i_from_below   (w_below),
            .o_win          (w_win[j]),
            .o_ok           (w_ok[j])
        );
    end

    wbps_decide #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_decide (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1       (w_s1),
        .i_ok       (w_ok),
        .i_len_eff  (w_len_eff),
        .i_base     (r_base),
        .o_s1_pop   (w_s1_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_align_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_align <= LW'(MAX_PATTERN))
        else $error("row alignment beyond the cell count");

    a_align_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_align != $past(r_align)) |->
            ((r_align == LW'($past(r_align) + 1)) || (r_align == LW'($past(r_align) - 1))))
        else $error("row alignment jumped by more than one cell");

    a_scan_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clear |=> (r_seen == '0))
        else $error("byte count not cleared after the last byte");
`endif

endmodule
